// ===== src/sclt_pkg.sv =====
// Shared types and constants for the serial command line tokenizer.
// No dependencies; every other file uses this package by scoped names.
package sclt_pkg;

    localparam int LINE_BYTES  = 64;
    localparam int MAX_PARAMS  = 4;
    localparam int TOKEN_BYTES = 8;

    // characters kept per token
    localparam int KEEP_BYTES = TOKEN_BYTES - 1;

    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 4;
    localparam int LEN_W   = 3;
    localparam int CHARS_W = 56;
    localparam int LANES   = CHARS_W / BYTE_W;

    localparam int FILL_W = $clog2(LINE_BYTES);
    localparam int SIDX_W = (MAX_PARAMS + 1 > 1) ? $clog2(MAX_PARAMS + 1) : 1;
    localparam int SCNT_W = $clog2(MAX_PARAMS + 2);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        CMD_CHAR = 2'd0,
        CMD_SEP  = 2'd1,
        CMD_END  = 2'd2,
        CMD_DROP = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [BYTE_W-1:0] data;
    } qentry_t;

endpackage

// ===== src/sclt_front.sv =====
// Front end: accepts received bytes, tracks the line fill count and
// classifies each byte into a command for the back end. Uses sclt_pkg.
module sclt_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sclt_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                           q_full,
    output logic                           q_push,
    output sclt_pkg::qentry_t              q_entry
);

    logic [sclt_pkg::FILL_W-1:0] fill_reg;
    logic [sclt_pkg::FILL_W-1:0] fill_next;
    logic                        is_lf;
    logic                        is_sep;
    logic                        at_limit;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    assign is_lf    = (rx_byte == sclt_pkg::CH_LF);
    assign is_sep   = (rx_byte == sclt_pkg::CH_SPACE) || (rx_byte == sclt_pkg::CH_NUL);
    assign at_limit = (fill_reg == sclt_pkg::FILL_W'(sclt_pkg::LINE_BYTES - 1));

    always_comb
    begin
        fill_next     = fill_reg;
        q_entry.data  = rx_byte;
        q_entry.cmd   = sclt_pkg::CMD_CHAR;
        priority if (is_lf)
        begin
            q_entry.cmd = sclt_pkg::CMD_END;
            fill_next   = '0;
        end
        else if (at_limit)
        begin
            // buffer full: line is dropped silently
            q_entry.cmd = sclt_pkg::CMD_DROP;
            fill_next   = '0;
        end
        else
        begin
            q_entry.cmd = is_sep ? sclt_pkg::CMD_SEP : sclt_pkg::CMD_CHAR;
            fill_next   = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (q_push)
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== src/sclt_queue.sv =====
// Short command queue between front and back end.
// Uses sclt_pkg for depth and entry type.
module sclt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sclt_pkg::qentry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output sclt_pkg::qentry_t pop_entry
);

    sclt_pkg::qentry_t           mem_reg [sclt_pkg::QDEPTH];
    logic [sclt_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [sclt_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [sclt_pkg::QCNT_W-1:0] count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign full      = (count_reg == sclt_pkg::QCNT_W'(sclt_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == sclt_pkg::QPTR_W'(sclt_pkg::QDEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == sclt_pkg::QPTR_W'(sclt_pkg::QDEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/sclt_back.sv =====
// Back end: builds tokens from the command stream, keeps one slot per
// token, up to MAX_PARAMS+1, and emits all slots on end of line. Uses sclt_pkg.
module sclt_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  sclt_pkg::qentry_t               q_entry,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sclt_pkg::SLOT_W-1:0]     slot_index,
    output logic [sclt_pkg::LEN_W-1:0]      token_length,
    output logic [sclt_pkg::CHARS_W-1:0]    token_chars,
    output logic                            last_slot
);

    typedef enum logic {
        ST_RUN,
        ST_EMIT
    } state_t;

    state_t                        state_reg;
    logic                          in_tok_reg;
    logic [sclt_pkg::LEN_W-1:0]    cur_len_reg;
    logic [sclt_pkg::CHARS_W-1:0]  cur_chars_reg;
    logic [sclt_pkg::SCNT_W-1:0]   slot_cnt_reg;
    logic [sclt_pkg::SIDX_W-1:0]   emit_idx_reg;
    logic                          out_valid_reg;
    logic [sclt_pkg::SLOT_W-1:0]   slot_index_reg;
    logic [sclt_pkg::LEN_W-1:0]    token_length_reg;
    logic [sclt_pkg::CHARS_W-1:0]  token_chars_reg;
    logic                          last_slot_reg;

    logic [sclt_pkg::LEN_W-1:0]    slot_len_reg   [sclt_pkg::MAX_PARAMS + 1];
    logic [sclt_pkg::CHARS_W-1:0]  slot_chars_reg [sclt_pkg::MAX_PARAMS + 1];

    logic [sclt_pkg::LEN_W-1:0]    base_len;
    logic [sclt_pkg::CHARS_W-1:0]  base_chars;
    logic [sclt_pkg::LEN_W-1:0]    add_len;
    logic [sclt_pkg::CHARS_W-1:0]  add_chars;
    logic                          is_flush;
    logic                          slot_store;
    logic                          slot_full;
    logic                          out_load;
    logic                          emit_present;
    logic                          emit_last;

    assign q_pop = (state_reg == ST_RUN) && q_valid;

    // append one character to the open token, truncating past KEEP_BYTES
    always_comb
    begin
        base_len   = in_tok_reg ? cur_len_reg : '0;
        base_chars = in_tok_reg ? cur_chars_reg : '0;
        add_chars  = base_chars;
        for (int j = 0; j < sclt_pkg::LANES; j++)
        begin
            if (j < sclt_pkg::KEEP_BYTES && base_len == sclt_pkg::LEN_W'(j))
            begin
                add_chars[j*sclt_pkg::BYTE_W +: sclt_pkg::BYTE_W] = q_entry.data;
            end
        end
        add_len = (base_len < sclt_pkg::LEN_W'(sclt_pkg::KEEP_BYTES)) ?
                  base_len + 1'b1 : base_len;
    end

    assign is_flush   = q_pop && ((q_entry.cmd == sclt_pkg::CMD_SEP) ||
                                  (q_entry.cmd == sclt_pkg::CMD_END));
    assign slot_full  = (slot_cnt_reg > sclt_pkg::SCNT_W'(sclt_pkg::MAX_PARAMS));
    assign slot_store = is_flush && in_tok_reg && !slot_full;

    assign out_load     = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign emit_present = (sclt_pkg::SCNT_W'(emit_idx_reg) < slot_cnt_reg);
    assign emit_last    = (emit_idx_reg == sclt_pkg::SIDX_W'(sclt_pkg::MAX_PARAMS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_RUN;
            in_tok_reg       <= 1'b0;
            cur_len_reg      <= '0;
            cur_chars_reg    <= '0;
            slot_cnt_reg     <= '0;
            emit_idx_reg     <= '0;
            out_valid_reg    <= 1'b0;
            slot_index_reg   <= '0;
            token_length_reg <= '0;
            token_chars_reg  <= '0;
            last_slot_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_RUN:
                begin
                    if (q_pop)
                    begin
                        unique case (q_entry.cmd)
                            sclt_pkg::CMD_CHAR:
                            begin
                                in_tok_reg    <= 1'b1;
                                cur_len_reg   <= add_len;
                                cur_chars_reg <= add_chars;
                            end
                            sclt_pkg::CMD_SEP,
                            sclt_pkg::CMD_END:
                            begin
                                if (in_tok_reg && !slot_full)
                                begin
                                    slot_cnt_reg <= slot_cnt_reg + 1'b1;
                                end
                                in_tok_reg <= 1'b0;
                                if (q_entry.cmd == sclt_pkg::CMD_END)
                                begin
                                    state_reg    <= ST_EMIT;
                                    emit_idx_reg <= '0;
                                end
                            end
                            sclt_pkg::CMD_DROP:
                            begin
                                in_tok_reg   <= 1'b0;
                                slot_cnt_reg <= '0;
                            end
                            default:
                            begin
                                in_tok_reg <= in_tok_reg;
                            end
                        endcase
                    end
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg    <= 1'b1;
                        slot_index_reg   <= sclt_pkg::SLOT_W'(emit_idx_reg);
                        token_length_reg <= emit_present ? slot_len_reg[emit_idx_reg] : '0;
                        token_chars_reg  <= emit_present ? slot_chars_reg[emit_idx_reg] : '0;
                        last_slot_reg    <= emit_last;
                        if (emit_last)
                        begin
                            state_reg    <= ST_RUN;
                            slot_cnt_reg <= '0;
                            emit_idx_reg <= '0;
                        end
                        else
                        begin
                            emit_idx_reg <= emit_idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    // slots past the fill count read as empty, so no clearing is needed
    always_ff @(posedge clk)
    begin
        if (slot_store)
        begin
            slot_len_reg[slot_cnt_reg[sclt_pkg::SIDX_W-1:0]]   <= cur_len_reg;
            slot_chars_reg[slot_cnt_reg[sclt_pkg::SIDX_W-1:0]] <= cur_chars_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot_index   = slot_index_reg;
    assign token_length = token_length_reg;
    assign token_chars  = token_chars_reg;
    assign last_slot    = last_slot_reg;

    a_no_pop_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !q_pop)
        else $error("queue popped while emitting slots");

    a_slot_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_cnt_reg <= sclt_pkg::SCNT_W'(sclt_pkg::MAX_PARAMS + 1))
        else $error("slot count out of range");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_len_reg <= sclt_pkg::LEN_W'(sclt_pkg::KEEP_BYTES))
        else $error("token length exceeds kept bytes");

    a_line_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && emit_last) |=> (state_reg == ST_RUN) && (slot_cnt_reg == '0))
        else $error("line state not cleared after last slot");

    a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (token_length_reg == '0)) |-> (token_chars_reg == '0))
        else $error("empty slot carries characters");

endmodule

// ===== src/serial_command_line_tokenizer.sv =====
// Top level of the serial command line tokenizer: front end, command
// queue and back end. Uses sclt_pkg, sclt_front, sclt_queue, sclt_back.
//
//  channel  signals                                         direction
//  in       in_valid, in_stall, rx_byte                     byte in
//  out      out_valid, out_stall, slot_index, token_length, result out
//           token_chars, last_slot
//
// The front end takes one byte per cycle while the 4-entry queue has room.
// The back end retires one queued byte per cycle while not emitting; a line feed
// starts output of all MAX_PARAMS+1 slots, one slot at a time, paced by out_stall.
// While the back end emits, bytes keep filling the queue until it is full.
// Reset clears fill count, queue and token state; no clearing pass is needed.
module serial_command_line_tokenizer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sclt_pkg::BYTE_W-1:0]     rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sclt_pkg::SLOT_W-1:0]     slot_index,
    output logic [sclt_pkg::LEN_W-1:0]      token_length,
    output logic [sclt_pkg::CHARS_W-1:0]    token_chars,
    output logic                            last_slot
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    sclt_pkg::qentry_t push_entry;
    sclt_pkg::qentry_t pop_entry;

    sclt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    sclt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .pop_entry  (pop_entry)
    );

    sclt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (pop_entry),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slot_index   (slot_index),
        .token_length (token_length),
        .token_chars  (token_chars),
        .last_slot    (last_slot)
    );

endmodule
